[rtl/core/ric_pkg.sv]
// ----------------------------------------------------------------------------
// ric_pkg
// Shared types and codes for the reference-counted ID allocator.
// ----------------------------------------------------------------------------
package ric_pkg;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned STATUS_W = 2;

  // operation codes
  localparam logic [FUNC_W-1:0] FUNC_REQUEST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]     result_id;
    logic [STATUS_W-1:0] status;
    logic                freed;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_t;

  // flags from the count unit about the count that was read
  typedef struct packed {
    logic zero;
    logic one;
    logic max;
  } cnt_flags_t;

endpackage

[rtl/core/ric_count_ram.sv]
// ----------------------------------------------------------------------------
// ric_count_ram
// Reference count table: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ric_count_ram #(
  parameter int unsigned DEPTH  = 256,
  parameter int unsigned DATA_W = 8,
  parameter int unsigned ADDR_W = 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/ric_count_alu.sv]
// ----------------------------------------------------------------------------
// ric_count_alu
// Shared count unit: zero / one / saturation test and increment, decrement or set.
// ----------------------------------------------------------------------------
module ric_count_alu #(
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic [ric_pkg::FUNC_W-1:0] func,
  input  logic [COUNT_BITS-1:0]      cnt,
  output logic [COUNT_BITS-1:0]      cnt_nxt,
  output ric_pkg::cnt_flags_t        flags
);

  localparam logic [COUNT_BITS-1:0] CntOne = COUNT_BITS'(1);

  always_comb begin
    flags.zero = (cnt == '0);
    flags.one  = (cnt == CntOne);
    flags.max  = (cnt == '1);
    unique case (func)
      ric_pkg::FUNC_REQUEST:  cnt_nxt = CntOne;
      ric_pkg::FUNC_REGISTER: cnt_nxt = cnt + CntOne;
      ric_pkg::FUNC_RELEASE:  cnt_nxt = cnt - CntOne;
      default:                cnt_nxt = cnt;
    endcase
  end

endmodule

[rtl/core/refcounted_id_allocator_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_id_allocator_unit
// Reference-counted ID allocator with a next-candidate search pointer.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count table to zero, one entry per cycle,
// and stalls its input meanwhile; configuration writes are taken at any time.
// A register or release passes through table read, update and result. A
// request reads from the search pointer on and skips each used ID, since the
// single table read port checks one entry per cycle, until it finds a free
// ID or runs off the end of the table. A request that finds the pointer
// already past the table, and an unused operation code, go straight to the
// result, which waits while the output register is still stalled. One item
// is worked on at a time. The finished result sits in an output register, so
// the next item is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module refcounted_id_allocator_unit #(
  parameter int unsigned NUM_IDS    = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ric_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ric_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int unsigned AW  = $clog2(NUM_IDS);
  localparam int unsigned PW  = $clog2(NUM_IDS + 1);
  localparam int unsigned XW  = PW + ric_pkg::ID_W;
  localparam logic [PW-1:0] PtrEnd  = PW'(NUM_IDS);
  localparam logic [XW-1:0] IdLimit = XW'(NUM_IDS);
  localparam logic [AW-1:0] ClrLast = AW'(NUM_IDS - 1);

  ric_pkg::state_t            state_r, state_nxt;
  logic [PW-1:0]              ptr_r, ptr_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic [ric_pkg::FUNC_W-1:0] func_r, func_nxt;
  logic [ric_pkg::ID_W-1:0]   id_r, id_nxt;
  ric_pkg::out_item_t         res_r, res_nxt;
  ric_pkg::out_item_t         out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       reuse_r, reuse_nxt;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [COUNT_BITS-1:0] wr_data, rd_data, cnt_nxt;
  ric_pkg::cnt_flags_t   flags;

  logic [PW-1:0]         ptr_inc;
  logic [XW-1:0]         in_id_x, id_x, ptr_x;
  logic [AW+7:0]         ptr_wide;
  logic                  freed;

  ric_count_ram #(
    .DEPTH  (NUM_IDS),
    .DATA_W (COUNT_BITS),
    .ADDR_W (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ric_count_alu #(
    .COUNT_BITS (COUNT_BITS)
  ) u_alu (
    .func    (func_r),
    .cnt     (rd_data),
    .cnt_nxt (cnt_nxt),
    .flags   (flags)
  );

  assign ptr_inc  = ptr_r + PW'(1);
  assign in_id_x  = {{PW{1'b0}}, in_data.id};
  assign id_x     = {{PW{1'b0}}, id_r};
  assign ptr_x    = {{ric_pkg::ID_W{1'b0}}, ptr_r};
  assign ptr_wide = {8'd0, ptr_r[AW-1:0]};

  assign in_stall  = (state_r != ric_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ric_pkg::ST_CLEAR;
      ptr_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      reuse_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      reuse_r     <= reuse_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    clr_nxt       = clr_r;
    func_nxt      = func_r;
    id_nxt        = id_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    reuse_nxt     = (cfg_valid && cfg_ready) ? cfg_data : reuse_r;
    wr_en         = 1'b0;
    wr_addr       = ptr_r[AW-1:0];
    wr_data       = cnt_nxt;
    rd_en         = 1'b0;
    rd_addr       = ptr_r[AW-1:0];
    freed         = 1'b0;

    unique case (state_r)
      ric_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == ClrLast) begin
          state_nxt = ric_pkg::ST_IDLE;
        end
      end

      ric_pkg::ST_IDLE: begin
        if (in_valid) begin
          func_nxt          = in_data.func;
          id_nxt            = in_data.id;
          res_nxt.result_id = in_data.id;
          res_nxt.status    = ric_pkg::STATUS_OK;
          res_nxt.freed     = 1'b0;
          state_nxt         = ric_pkg::ST_RESP;
          unique case (in_data.func)
            ric_pkg::FUNC_REQUEST: begin
              if (ptr_r == PtrEnd) begin
                res_nxt.result_id = '0;
                res_nxt.status    = ric_pkg::STATUS_EXHAUSTED;
              end else begin
                rd_en     = 1'b1;
                state_nxt = ric_pkg::ST_SCAN;
              end
            end
            ric_pkg::FUNC_REGISTER,
            ric_pkg::FUNC_RELEASE: begin
              if (in_id_x < IdLimit) begin
                rd_en     = 1'b1;
                rd_addr   = in_data.id[AW-1:0];
                state_nxt = ric_pkg::ST_UPDATE;
              end else if (in_data.func == ric_pkg::FUNC_RELEASE) begin
                // out-of-table id is never below the pointer: no move
                res_nxt.freed = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ric_pkg::ST_SCAN: begin
        if (flags.zero) begin
          wr_en             = 1'b1;
          res_nxt.result_id = ptr_wide[7:0];
          state_nxt         = ric_pkg::ST_RESP;
        end else begin
          // advance; fetch the next candidate unless the table end is reached
          ptr_nxt = ptr_inc;
          if (ptr_inc == PtrEnd) begin
            res_nxt.result_id = '0;
            res_nxt.status    = ric_pkg::STATUS_EXHAUSTED;
            state_nxt         = ric_pkg::ST_RESP;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_inc[AW-1:0];
          end
        end
      end

      ric_pkg::ST_UPDATE: begin
        wr_addr   = id_r[AW-1:0];
        state_nxt = ric_pkg::ST_RESP;
        if (func_r == ric_pkg::FUNC_REGISTER) begin
          if (flags.max) begin
            res_nxt.status = ric_pkg::STATUS_SATURATED;
          end else begin
            wr_en = 1'b1;
          end
        end else begin
          wr_en         = !flags.zero;
          freed         = flags.zero || flags.one;
          res_nxt.freed = freed;
          if (freed && reuse_r && (id_x < ptr_x)) begin
            ptr_nxt = id_x[PW-1:0];
          end
        end
      end

      ric_pkg::ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ric_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = ric_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[verif/ric_alloc_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ric_alloc_monitor
// Watches the input, result and configuration channels of the ID allocator,
// keeps its own copy of the count table and search pointer, predicts one
// reply per accepted item and compares each returned reply in order.
// ----------------------------------------------------------------------------
module ric_alloc_monitor #(
  parameter int unsigned NUM_IDS    = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  ric_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  ric_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic               cfg_data,
  output int unsigned        mismatch_count,
  output int unsigned        replies_owed
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] use_count [NUM_IDS];
  int unsigned           alloc_ptr;
  logic                  reuse_en;
  ric_pkg::out_item_t    expected_replies [$];
  int unsigned           miss_n = 0;

  function automatic ric_pkg::out_item_t predict_reply(input ric_pkg::in_item_t it);
    ric_pkg::out_item_t r;
    int unsigned        p;
    r.result_id = it.id;
    r.status    = ric_pkg::STATUS_OK;
    r.freed     = 1'b0;
    case (it.func)
      ric_pkg::FUNC_REQUEST: begin
        p = alloc_ptr;
        while (p < NUM_IDS && use_count[p] != '0) p++;
        alloc_ptr = p;
        if (p < NUM_IDS) begin
          use_count[p] = COUNT_BITS'(1);
          r.result_id  = ric_pkg::ID_W'(p);
        end else begin
          r.status    = ric_pkg::STATUS_EXHAUSTED;
          r.result_id = '0;
        end
      end
      ric_pkg::FUNC_REGISTER: begin
        if (use_count[it.id] == COUNT_MAX) r.status = ric_pkg::STATUS_SATURATED;
        else use_count[it.id]++;
      end
      ric_pkg::FUNC_RELEASE: begin
        // a release of an unused ID reports freed without touching the count
        if (use_count[it.id] != '0) use_count[it.id]--;
        r.freed = (use_count[it.id] == '0);
        if (r.freed && it.id < alloc_ptr && reuse_en) alloc_ptr = it.id;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    ric_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < NUM_IDS; i++) use_count[i] = '0;
      alloc_ptr = 0;
      reuse_en  = 1'b1;
      expected_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          miss_n++;
          if (miss_n <= 10)
            $display("%0t: unexpected reply id=%0d status=%0d freed=%0d", $time,
                     out_data.result_id, out_data.status, out_data.freed);
        end else begin
          want = expected_replies.pop_front();
          if (out_data.result_id !== want.result_id || out_data.status !== want.status ||
              out_data.freed !== want.freed) begin
            miss_n++;
            if (miss_n <= 10)
              $display("%0t: mismatch exp id=%0d st=%0d fr=%0d got id=%0d st=%0d fr=%0d",
                       $time, want.result_id, want.status, want.freed,
                       out_data.result_id, out_data.status, out_data.freed);
          end
        end
      end
      if (in_valid && !in_stall) expected_replies.push_back(predict_reply(in_data));
      if (cfg_valid && cfg_ready) reuse_en = cfg_data;
    end
    mismatch_count <= miss_n;
    replies_owed   <= expected_replies.size();
  end

endmodule

[verif/tb_refcounted_id_allocator_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_refcounted_id_allocator_unit
// Drives requests, registers and releases into the ID allocator with random
// idling on both channels, toggles the reuse setting between phases, walks
// the table to exhaustion and one count to saturation, and reports the
// verdict from the monitor's mismatch count.
// ----------------------------------------------------------------------------
module tb_refcounted_id_allocator_unit;

  localparam logic [ric_pkg::FUNC_W-1:0] FUNC_UNUSED  = 2'd3;
  localparam int unsigned                LONG_HOLD    = 300;
  localparam int unsigned                DRAIN_CYCLES = 20;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ric_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_stall;
  ric_pkg::out_item_t out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic               cfg_data;
  int unsigned        mismatch_count;
  int unsigned        replies_owed;

  bit src_gaps_on   = 1'b1;
  bit sink_idle_on  = 1'b1;
  bit sink_hold_req = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  refcounted_id_allocator_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  ric_alloc_monitor u_monitor (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .replies_owed   (replies_owed)
  );

  task automatic send_item(input ric_pkg::in_item_t it);
    if (src_gaps_on && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      in_data  <= ric_pkg::in_item_t'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(input logic [ric_pkg::FUNC_W-1:0] f,
                         input logic [ric_pkg::ID_W-1:0] id);
    ric_pkg::in_item_t it;
    it.func = f;
    it.id   = id;
    send_item(it);
  endtask

  // mostly low IDs, where allocations land, so releases and registers hit live entries
  function automatic ric_pkg::in_item_t random_op(input int unsigned req_pct,
                                                  input int unsigned reg_pct);
    ric_pkg::in_item_t it;
    int unsigned       r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 9) < 7) it.id = ric_pkg::ID_W'($urandom_range(0, 47));
    else it.id = ric_pkg::ID_W'($urandom);
    if (r < 4) it.func = FUNC_UNUSED;
    else if (r < 4 + req_pct) it.func = ric_pkg::FUNC_REQUEST;
    else if (r < 4 + req_pct + reg_pct) it.func = ric_pkg::FUNC_REGISTER;
    else it.func = ric_pkg::FUNC_RELEASE;
    return it;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic write_reuse(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (sink_hold_req) begin
        // hold off long enough for the block to back up into its input
        sink_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (sink_idle_on) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    logic [ric_pkg::ID_W-1:0] sat_id;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_op(ric_pkg::FUNC_REQUEST,  8'h00);
    send_op(ric_pkg::FUNC_REQUEST,  8'hFF);
    send_op(ric_pkg::FUNC_REQUEST,  8'hA5);
    send_op(ric_pkg::FUNC_REGISTER, 8'h00);
    send_op(ric_pkg::FUNC_REGISTER, 8'hFF);
    send_op(ric_pkg::FUNC_RELEASE,  8'h01);   // pull pointer back to 1
    send_op(ric_pkg::FUNC_REQUEST,  8'h5A);
    send_op(ric_pkg::FUNC_RELEASE,  8'h00);
    send_op(ric_pkg::FUNC_RELEASE,  8'h00);
    send_op(ric_pkg::FUNC_RELEASE,  8'h00);   // release of an unused ID
    send_op(ric_pkg::FUNC_RELEASE,  8'hC8);
    send_op(FUNC_UNUSED,            8'hAA);
    send_op(FUNC_UNUSED,            8'h55);
    send_op(ric_pkg::FUNC_REQUEST,  8'h00);
    send_op(ric_pkg::FUNC_RELEASE,  8'hFF);
    send_op(ric_pkg::FUNC_REGISTER, 8'h80);
    send_op(ric_pkg::FUNC_REQUEST,  8'hFF);
    send_op(ric_pkg::FUNC_REGISTER, 8'h03);
    send_op(ric_pkg::FUNC_RELEASE,  8'h02);
    send_op(ric_pkg::FUNC_REQUEST,  8'h00);
    send_op(ric_pkg::FUNC_RELEASE,  8'h80);
    send_op(ric_pkg::FUNC_RELEASE,  8'h7F);
    wait_drained();

    sink_hold_req = 1'b1;
    repeat (170) send_item(random_op(40, 25));
    wait_drained();

    // without reuse the pointer only climbs, so request-heavy traffic exhausts the table
    write_reuse(1'b0);
    repeat (260) send_item(random_op(80, 6));
    wait_drained();

    write_reuse(1'b1);
    repeat (100) send_item(random_op(30, 25));

    src_gaps_on  = 1'b0;
    sink_idle_on = 1'b0;
    sat_id = ric_pkg::ID_W'($urandom_range(0, 255));
    repeat (257) send_op(ric_pkg::FUNC_REGISTER, sat_id);
    send_op(ric_pkg::FUNC_RELEASE,  sat_id);
    send_op(ric_pkg::FUNC_REGISTER, sat_id);
    send_op(ric_pkg::FUNC_REGISTER, sat_id);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && replies_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
